FILE: rtl/obpl_pkg.sv
// Shared types and constants for the order book price level table.
package obpl_pkg;

    localparam int LEVELS = 64;
    localparam int IDX_W = $clog2(LEVELS);
    localparam int CNT_W = $clog2(LEVELS + 1);
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_LEVEL = 1'b1;
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic        side;
        logic [31:0] price;
        logic [30:0] amount;
        logic [63:0] stamp;
        logic        last_in_message;
    } t_in;

    typedef struct packed {
        logic [31:0] bid_px;
        logic [30:0] bid_qty;
        logic        bid_valid;
        logic [31:0] ask_px;
        logic [30:0] ask_qty;
        logic        ask_valid;
        logic [63:0] time_out;
        logic        overflowed;
    } t_out;

    // Classified operation handed from front to back.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LEVEL_SET,
        OP_LEVEL_DEL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        side;
        logic [31:0] price;
        logic [30:0] amount;
        logic [63:0] stamp;
        logic        last;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_REPORT
    } t_state;

endpackage

FILE: rtl/obpl_front.sv
// Front end: accept transactions, classify them and queue them for the back end.
module obpl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  obpl_pkg::t_in i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_take,
    output obpl_pkg::t_cmd o_cmd
);
    import obpl_pkg::*;

    t_cmd r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd n_cmd;
    logic push, pop;

    always_comb begin
        n_cmd.side   = i_data.side;
        n_cmd.price  = i_data.price;
        n_cmd.amount = i_data.amount;
        n_cmd.stamp  = i_data.stamp;
        n_cmd.last   = i_data.last_in_message;
        if (i_data.cmd == CMD_CLEAR) begin
            n_cmd.op = OP_CLEAR;
        end else if (i_data.amount == '0) begin
            n_cmd.op = OP_LEVEL_DEL;
        end else begin
            n_cmd.op = OP_LEVEL_SET;
        end
    end

    assign o_stall     = (r_cnt == QCNT_W'(QDEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(pop);
        end
        if (push) r_q[r_wp] <= n_cmd;
    end
endmodule

FILE: rtl/obpl_side.sv
// One sorted price-level table as a row of cells with compare-all and shift.
module obpl_side (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_is_ask,
    input  logic        i_clear,
    input  logic        i_cmp,
    input  logic        i_apply,
    input  logic [31:0] i_price,
    input  logic [30:0] i_amount,
    output logic        o_drop,
    output logic [31:0] o_best_price,
    output logic [30:0] o_best_amount,
    output logic        o_nonempty
);
    import obpl_pkg::*;

    logic [31:0] r_price [LEVELS];
    logic [30:0] r_amt   [LEVELS];
    logic [LEVELS-1:0] r_used;
    logic [LEVELS-1:0] r_ahead, r_eq;
    logic [LEVELS-1:0] hit, ins_pos;
    logic found, full;

    // Compare stage: register per-cell relations.
    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_ahead[k] <= r_used[k] &&
                    (i_is_ask ? (r_price[k] < i_price) : (r_price[k] > i_price));
                r_eq[k]    <= r_used[k] && (r_price[k] == i_price);
            end
        end
    end

    assign hit   = r_eq;
    assign found = |r_eq;
    assign full  = r_used[LEVELS-1];
    // The insert position is the first cell not ahead; ahead cells form a prefix.
    always_comb begin
        ins_pos[0] = !r_ahead[0];
        for (int k = 1; k < LEVELS; k++) begin
            ins_pos[k] = !r_ahead[k] && r_ahead[k-1];
        end
    end
    assign o_drop = i_apply && !found && (i_amount != '0) && full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_clear) begin
            r_used <= '0;
        end else if (i_apply) begin
            if (found && i_amount == '0) begin
                r_used <= {1'b0, r_used[LEVELS-1:1]};
            end else if (!found && i_amount != '0 && ins_pos != '0) begin
                r_used <= {r_used[LEVELS-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            if (found) begin
                if (i_amount == '0) begin
                    // Close the gap: cells at or past the hit take the next one.
                    for (int k = 0; k < LEVELS - 1; k++) begin
                        if (!r_ahead[k] && r_used[k]) begin
                            r_price[k] <= r_price[k+1];
                            r_amt[k]   <= r_amt[k+1];
                        end
                    end
                end else begin
                    for (int k = 0; k < LEVELS; k++) begin
                        if (hit[k]) r_amt[k] <= i_amount;
                    end
                end
            end else if (i_amount != '0) begin
                if (ins_pos[0]) begin
                    r_price[0] <= i_price;
                    r_amt[0]   <= i_amount;
                end
                for (int k = 1; k < LEVELS; k++) begin
                    if (ins_pos[k]) begin
                        r_price[k] <= i_price;
                        r_amt[k]   <= i_amount;
                    end else if (!r_ahead[k]) begin
                        r_price[k] <= r_price[k-1];
                        r_amt[k]   <= r_amt[k-1];
                    end
                end
            end
        end
    end

    assign o_nonempty    = r_used[0];
    assign o_best_price  = r_used[0] ? r_price[0] : '0;
    assign o_best_amount = r_used[0] ? r_amt[0] : '0;
endmodule

FILE: rtl/obpl_back.sv
// Back end: sequence table updates and build result transactions.
module obpl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_take,
    input  obpl_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output obpl_pkg::t_out o_data
);
    import obpl_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic   r_drop, r_ovalid;
    t_out   r_out;
    logic   cmp, apply, clear, bid_drop, ask_drop;
    logic   bid_ne, ask_ne;
    logic [31:0] bid_p, ask_p;
    logic [30:0] bid_a, ask_a;
    logic [31:0] cmd_price;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_cmd_valid) n_state = ST_APPLY;
            ST_APPLY:  n_state = r_cmd.last ? ST_REPORT : ST_IDLE;
            ST_REPORT: if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = (r_state == ST_IDLE);
        cmp        = (r_state == ST_IDLE) && i_cmd_valid;
        apply      = (r_state == ST_APPLY) && (r_cmd.op != OP_CLEAR);
        clear      = (r_state == ST_APPLY) && (r_cmd.op == OP_CLEAR);
    end

    // Compare runs against the queue head; apply uses the latched copy.
    assign cmd_price = (r_state == ST_IDLE) ? i_cmd.price : r_cmd.price;

    obpl_side u_bid (
        .i_clk, .i_rst_n, .i_is_ask(1'b0), .i_clear(clear), .i_cmp(cmp),
        .i_apply(apply && r_cmd.side == SIDE_BID), .i_price(cmd_price),
        .i_amount(r_cmd.amount), .o_drop(bid_drop), .o_best_price(bid_p),
        .o_best_amount(bid_a), .o_nonempty(bid_ne)
    );
    obpl_side u_ask (
        .i_clk, .i_rst_n, .i_is_ask(1'b1), .i_clear(clear), .i_cmp(cmp),
        .i_apply(apply && r_cmd.side == SIDE_ASK), .i_price(cmd_price),
        .i_amount(r_cmd.amount), .o_drop(ask_drop), .o_best_price(ask_p),
        .o_best_amount(ask_a), .o_nonempty(ask_ne)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_APPLY) r_drop <= r_drop | bid_drop | ask_drop;
            if (r_state == ST_REPORT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
                r_drop   <= 1'b0;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (cmp) r_cmd <= i_cmd;
        if (r_state == ST_REPORT && (!r_ovalid || !i_stall)) begin
            r_out.bid_px     <= bid_p;
            r_out.bid_qty    <= bid_a;
            r_out.bid_valid  <= bid_ne;
            r_out.ask_px     <= ask_p;
            r_out.ask_qty    <= ask_a;
            r_out.ask_valid  <= ask_ne;
            r_out.time_out   <= r_cmd.stamp;
            r_out.overflowed <= r_drop;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule

FILE: rtl/order_book_price_levels.sv
// Top level of the order book price level table.
// A transaction that closes a message raises o_valid after the queue and the compare,
// apply and report states. Each one takes a compare then shift pass over the cell row,
// plus a report step if it closes a message; the back end takes the next only in idle.
// A 2-entry queue lets input keep flowing while the back end or the output stalls.
// Reset (synchronous, active low) empties both tables, the queue and the drop flag.
module order_book_price_levels (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  obpl_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output obpl_pkg::t_out  o_data
);
    import obpl_pkg::*;

    logic cmd_valid, cmd_take;
    t_cmd cmd;

    // Front: accept and classify into clear, set or delete.
    obpl_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    // Back: update the tables and report the top of book.
    obpl_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .o_valid, .i_stall, .o_data
    );
endmodule

FILE: rtl/obpl_checker.sv
// Port-level checks for the order book price level table.
module obpl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input obpl_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input obpl_pkg::t_out o_data
);
    import obpl_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_bid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.bid_valid |-> o_data.bid_px == '0) else $error("bid not zero");
    a_ask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.ask_valid |-> o_data.ask_qty == '0) else $error("ask not zero");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall) else $error("reset state");
endmodule

bind order_book_price_levels obpl_checker u_chk (.*);

FILE: tb/tb_order_book_price_levels.sv
// Self-checking testbench for the order book price level table.
module tb_order_book_price_levels;
    import obpl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_RANDOM = 1500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    order_book_price_levels dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #4 i_clk = ~i_clk;

    // Book shadow: one table per side, index 0 is the best level.
    logic [31:0] book_px [2][LEVELS];
    logic [30:0] book_qty [2][LEVELS];
    int book_depth [2];
    logic [63:0] last_stamp;
    logic dropped;

    t_out pending_quotes [$];
    int errors = 0;
    int idle_pct = 19;
    int quiet_cycles = 0;

    function automatic bit is_better(logic sd, logic [31:0] a, logic [31:0] b);
        return (sd == SIDE_ASK) ? (a < b) : (a > b);
    endfunction

    // Apply one transaction to the shadow book; queue a quote on message end.
    task automatic update_book(t_in t);
        int s;
        int n;
        int pos;
        t_out q;
        s = int'(t.side);
        last_stamp = t.stamp;
        if (t.cmd == CMD_CLEAR) begin
            book_depth[0] = 0;
            book_depth[1] = 0;
        end else begin
            n = book_depth[s];
            pos = 0;
            while (pos < n && is_better(t.side, book_px[s][pos], t.price)) pos++;
            if (pos < n && book_px[s][pos] == t.price) begin
                if (t.amount == 0) begin
                    for (int i = pos; i + 1 < n; i++) begin
                        book_px[s][i] = book_px[s][i+1];
                        book_qty[s][i] = book_qty[s][i+1];
                    end
                    book_depth[s] = n - 1;
                end else begin
                    book_qty[s][pos] = t.amount;
                end
            end else if (t.amount != 0) begin
                if (n >= LEVELS) begin
                    dropped = 1'b1;
                    n = LEVELS - 1;
                end
                if (pos < LEVELS) begin
                    for (int i = n; i > pos; i--) begin
                        book_px[s][i] = book_px[s][i-1];
                        book_qty[s][i] = book_qty[s][i-1];
                    end
                    book_px[s][pos] = t.price;
                    book_qty[s][pos] = t.amount;
                    book_depth[s] = n + 1;
                end
            end
        end
        if (t.last_in_message) begin
            q = '0;
            if (book_depth[0] > 0) begin
                q.bid_px = book_px[0][0];
                q.bid_qty = book_qty[0][0];
                q.bid_valid = 1'b1;
            end
            if (book_depth[1] > 0) begin
                q.ask_px = book_px[1][0];
                q.ask_qty = book_qty[1][0];
                q.ask_valid = 1'b1;
            end
            q.time_out = last_stamp;
            q.overflowed = dropped;
            dropped = 1'b0;
            pending_quotes.push_back(q);
        end
    endtask

    // Compare each delivered quote against the oldest prediction.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_quotes.size() == 0) begin
                $error("unexpected quote %p", o_data);
                errors++;
            end else begin
                e = pending_quotes.pop_front();
                if (o_data.bid_px !== e.bid_px) begin
                    $error("bid_px exp %0d got %0d", e.bid_px, o_data.bid_px);
                    errors++;
                end
                if (o_data.bid_qty !== e.bid_qty) begin
                    $error("bid_qty exp %0d got %0d", e.bid_qty, o_data.bid_qty);
                    errors++;
                end
                if (o_data.bid_valid !== e.bid_valid) begin
                    $error("bid_valid exp %0d got %0d", e.bid_valid, o_data.bid_valid);
                    errors++;
                end
                if (o_data.ask_px !== e.ask_px) begin
                    $error("ask_px exp %0d got %0d", e.ask_px, o_data.ask_px);
                    errors++;
                end
                if (o_data.ask_qty !== e.ask_qty) begin
                    $error("ask_qty exp %0d got %0d", e.ask_qty, o_data.ask_qty);
                    errors++;
                end
                if (o_data.ask_valid !== e.ask_valid) begin
                    $error("ask_valid exp %0d got %0d", e.ask_valid, o_data.ask_valid);
                    errors++;
                end
                if (o_data.time_out !== e.time_out) begin
                    $error("time_out exp %0h got %0h", e.time_out, o_data.time_out);
                    errors++;
                end
                if (o_data.overflowed !== e.overflowed) begin
                    $error("overflowed exp %0d got %0d", e.overflowed, o_data.overflowed);
                    errors++;
                end
            end
        end
    end

    // Stall the output at random; hold it open during quiet stretches.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    // Count cycles with no transaction on either side and stop if stuck.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("order_book_price_levels test failed");
            $finish;
        end
    end

    // Present one transaction and hold it until the block takes it.
    task automatic send_level(t_in t);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        update_book(t);
    endtask

    function automatic t_in mk(logic c, logic sd, logic [31:0] px, logic [30:0] qty,
                               logic [63:0] st, logic lst);
        t_in t;
        t.cmd = c; t.side = sd; t.price = px; t.amount = qty;
        t.stamp = st; t.last_in_message = lst;
        return t;
    endfunction

    // Random level, drawn from a narrow price band so hits and deletes occur.
    function automatic t_in rand_level(int band);
        t_in t;
        t.cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_LEVEL;
        t.side = 1'($urandom_range(1));
        if ($urandom_range(19) == 0) t.price = $urandom();
        else t.price = 32'd1000 + $urandom_range(band);
        t.amount = ($urandom_range(3) == 0) ? 31'd0 :
                   (($urandom_range(9) == 0) ? 31'h7FFF_FFFF : 31'($urandom()));
        t.stamp = {$urandom(), $urandom()};
        t.last_in_message = ($urandom_range(3) == 0);
        return t;
    endfunction

    // Directed rows: extremes, delete, replace, ignored absent delete, clear.
    t_in dir_rows [$];
    t_out dir_known [$];
    bit dir_has_known [$];

    initial begin
        t_out k;
        book_depth[0] = 0;
        book_depth[1] = 0;
        last_stamp = '0;
        dropped = 1'b0;

        // Empty book right after reset: known quote with only the stamp set.
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_BID, 32'd5, 31'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                              1'b1));
        k = '0; k.time_out = 64'hFFFF_FFFF_FFFF_FFFF;
        dir_known.push_back(k); dir_has_known.push_back(1'b1);
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_BID, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 64'd1, 1'b1));
        k = '0; k.bid_px = 32'hFFFF_FFFF; k.bid_qty = 31'h7FFF_FFFF; k.bid_valid = 1'b1;
        k.time_out = 64'd1;
        dir_known.push_back(k); dir_has_known.push_back(1'b1);
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_ASK, 32'd0, 31'd1, 64'd2, 1'b1));
        k.ask_valid = 1'b1; k.ask_qty = 31'd1; k.time_out = 64'd2;
        dir_known.push_back(k); dir_has_known.push_back(1'b1);
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_BID, 32'd10, 31'd7, 64'd3, 1'b0));
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_BID, 32'd10, 31'd9, 64'd4, 1'b0));
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_BID, 32'hFFFF_FFFF, 31'd0, 64'd5, 1'b1));
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_ASK, 32'd77, 31'd0, 64'd6, 1'b0));
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_ASK, 32'd50, 31'd3, 64'd7, 1'b1));
        dir_rows.push_back(mk(CMD_LEVEL, SIDE_ASK, 32'd0, 31'd0, 64'd8, 1'b1));
        dir_rows.push_back(mk(CMD_CLEAR, SIDE_ASK, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 64'd9, 1'b0));
        dir_rows.push_back(mk(CMD_CLEAR, SIDE_BID, 32'd0, 31'd0, 64'hA5A5, 1'b1));
        k = '0; k.time_out = 64'hA5A5;
        for (int i = 0; i < dir_rows.size() - 1; i++) begin
            if (dir_has_known.size() <= i) begin
                dir_has_known.push_back(1'b0); dir_known.push_back('0);
            end
        end
        dir_known.push_back(k); dir_has_known.push_back(1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_has_known[r] && dir_rows[r].last_in_message) begin
                send_level(dir_rows[r]);
                // The shadow has already pushed its quote; it must agree with the table.
                if (pending_quotes.size() > 0 && pending_quotes[$] !== dir_known[r]) begin
                    $error("directed row %0d: shadow %p table %p", r,
                           pending_quotes[$], dir_known[r]);
                    errors++;
                end
            end else begin
                send_level(dir_rows[r]);
            end
        end

        // Fill the bid side past capacity: ascending prices displace the worst level,
        // then a price below all stored levels is itself dropped.
        for (int i = 0; i < LEVELS + 4; i++)
            send_level(mk(CMD_LEVEL, SIDE_BID, 32'd2000 + i, 31'(100 + i), 64'(i), 1'b0));
        send_level(mk(CMD_LEVEL, SIDE_BID, 32'd1, 31'd5, 64'd500, 1'b1));
        send_level(mk(CMD_LEVEL, SIDE_BID, 32'd1, 31'd5, 64'd501, 1'b1));
        for (int i = 0; i < LEVELS + 2; i++)
            send_level(mk(CMD_LEVEL, SIDE_ASK, 32'd9000 - i, 31'd3, 64'(i), i[0]));

        // Let every pending quote drain before continuing.
        i_valid <= 1'b0;
        while (pending_quotes.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            // Quiet stretch with no idling on either side.
            idle_pct = (n >= 600 && n < 900) ? 0 : 19;
            // Random transactions from a narrow price band, with a wider band from transaction 1200 on.
            send_level(rand_level((n < 1200) ? 40 : 120));
        end
        i_valid <= 1'b0;

        while (pending_quotes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("order_book_price_levels test passed");
        end else begin
            $display("order_book_price_levels test failed");
        end
        $finish;
    end

endmodule
